>>> rtl/cbd_pkg.sv
// Package for the circular buffer deque: field widths, operation and status codes.
`default_nettype none

package cbd_pkg;

  localparam int KIND_W = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 10;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 11;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_BACK   = 3'd3,
    K_READ_AT    = 3'd4,
    K_CLEAR      = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

`default_nettype wire

>>> rtl/circular_buffer_deque.sv
// Double-ended queue held in a circular single-port-read, single-port-write memory.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_ready    in_kind, in_value, in_position
//   out_      output     out_valid / out_ready  out_status, out_front_value, out_back_value,
//                                               out_read_value, out_occupancy,
//                                               out_is_empty, out_is_full
//
// Pushes, failed operations, pops that leave the queue empty, clear and the unused
// kinds enter the holding stage on acceptance. Pops that leave entries behind and
// successful reads at a position pass through a read state: the new front, new back
// or requested entry comes from the store's one read port, whose data is registered.
// Reset clears the pointers and the count; the store is not swept and needs no
// clearing pass, since no entry is reached before it has been written.
// One finished result can wait in a holding stage while the output register is
// stalled; a new request is taken when no read is pending and that stage is free or being drained.
`default_nettype none

module circular_buffer_deque #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cbd_pkg::KIND_W-1:0]  in_kind,
  input  logic [cbd_pkg::VAL_W-1:0]   in_value,
  input  logic [cbd_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cbd_pkg::STAT_W-1:0]  out_status,
  output logic [cbd_pkg::VAL_W-1:0]   out_front_value,
  output logic [cbd_pkg::VAL_W-1:0]   out_back_value,
  output logic [cbd_pkg::VAL_W-1:0]   out_read_value,
  output logic [cbd_pkg::OCC_W-1:0]   out_occupancy,
  output logic                        out_is_empty,
  output logic                        out_is_full
);

  import cbd_pkg::*;

  // Pointer width, count width (must hold CAPACITY itself), and working widths
  // for the position compare and the wrapped front-plus-position address.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int SW = ((AW > POS_W) ? AW : POS_W) + 1;

  typedef enum logic {S_IDLE, S_READ} state_t;
  typedef enum logic [1:0] {D_FRONT, D_BACK, D_READ} dest_t;

  state_t                  state_r;
  dest_t                   dest_r, dest_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [AW-1:0]           tail_r, tail_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [DATA_WIDTH-1:0]   front_r, front_nxt;
  logic [DATA_WIDTH-1:0]   back_r, back_nxt;

  // Holding stage: the status and read value of a finished request.
  logic                    res_valid_r;
  status_t                 res_status_r, status_nxt;
  logic [DATA_WIDTH-1:0]   res_read_r;

  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [VAL_W-1:0]        out_front_r, out_back_r, out_read_r;
  logic [OCC_W-1:0]        out_occ_r;
  logic                    out_empty_r, out_full_r;

  // Store and its ports.
  logic [DATA_WIDTH-1:0]   mem [CAPACITY];
  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0]   mem_wdata, mem_rdata_r;

  logic                    acc, xfer;
  logic                    cnt_zero, cnt_one, cnt_full;
  logic [DATA_WIDTH-1:0]   in_data;
  logic [SW-1:0]           pos_sum;
  logic [AW-1:0]           pos_addr;
  logic [AW-1:0]           head_inc, head_dec, tail_inc, tail_dec;

  // The holding stage drains into the output register when that is free or
  // being taken; a request is accepted when no read is pending and the holding stage will be free.
  assign xfer     = res_valid_r && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE) && (!res_valid_r || xfer);
  assign acc      = in_valid && in_ready;

  assign cnt_zero = (count_r == '0);
  assign cnt_one  = (count_r == CW'(1));
  assign cnt_full = (count_r == CW'(CAPACITY));
  assign in_data  = DATA_WIDTH'(in_value);

  assign head_inc = (head_r == AW'(CAPACITY - 1)) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - AW'(1);
  assign tail_inc = (tail_r == AW'(CAPACITY - 1)) ? '0 : tail_r + AW'(1);
  assign tail_dec = (tail_r == '0) ? AW'(CAPACITY - 1) : tail_r - AW'(1);

  // A valid position is below the count, so the sum stays under twice the
  // capacity and a single compare-and-subtract wraps it.
  assign pos_sum  = SW'(head_r) + SW'(in_position);
  assign pos_addr = (pos_sum >= SW'(CAPACITY)) ? AW'(pos_sum - SW'(CAPACITY))
                                               : AW'(pos_sum);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    status_nxt = ST_OK;
    dest_nxt   = dest_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = in_data;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    if (acc) begin
      unique case (kind_t'(in_kind))
        K_PUSH_FRONT, K_PUSH_BACK: begin
          if (cnt_full) begin
            status_nxt = ST_FULL;
          end else if (cnt_zero) begin
            // The first entry always lands at index zero.
            head_nxt  = '0;
            tail_nxt  = '0;
            count_nxt = CW'(1);
            front_nxt = in_data;
            back_nxt  = in_data;
            mem_we    = 1'b1;
          end else if (kind_t'(in_kind) == K_PUSH_FRONT) begin
            head_nxt  = head_dec;
            count_nxt = count_r + CW'(1);
            front_nxt = in_data;
            mem_we    = 1'b1;
            mem_waddr = head_dec;
          end else begin
            tail_nxt  = tail_inc;
            count_nxt = count_r + CW'(1);
            back_nxt  = in_data;
            mem_we    = 1'b1;
            mem_waddr = tail_inc;
          end
        end
        K_POP_FRONT, K_POP_BACK: begin
          if (cnt_zero) begin
            status_nxt = ST_EMPTY;
          end else if (cnt_one) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            count_nxt = '0;
            front_nxt = '0;
            back_nxt  = '0;
          end else if (kind_t'(in_kind) == K_POP_FRONT) begin
            head_nxt  = head_inc;
            count_nxt = count_r - CW'(1);
            mem_re    = 1'b1;
            mem_raddr = head_inc;
            dest_nxt  = D_FRONT;
          end else begin
            tail_nxt  = tail_dec;
            count_nxt = count_r - CW'(1);
            mem_re    = 1'b1;
            mem_raddr = tail_dec;
            dest_nxt  = D_BACK;
          end
        end
        K_READ_AT: begin
          if (cnt_zero) begin
            status_nxt = ST_EMPTY;
          end else if (PW'(in_position) >= PW'(count_r)) begin
            status_nxt = ST_RANGE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pos_addr;
            dest_nxt  = D_READ;
          end
        end
        K_CLEAR: begin
          head_nxt  = '0;
          tail_nxt  = '0;
          count_nxt = '0;
          front_nxt = '0;
          back_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Store: one write and one registered read per cycle. A push and a read never
  // share a request, and a write lands before any later request reads it.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      dest_r  <= dest_nxt;

      // Output register: loaded from the holding stage. The cached front and
      // back and the count still describe the request being drained here,
      // since a new request updates them at this same edge.
      if (xfer) begin
        out_valid_r  <= 1'b1;
        out_status_r <= res_status_r;
        out_front_r  <= cnt_zero ? '0 : VAL_W'(front_r);
        out_back_r   <= cnt_zero ? '0 : VAL_W'(back_r);
        out_read_r   <= VAL_W'(res_read_r);
        out_occ_r    <= OCC_W'(count_r);
        out_empty_r  <= cnt_zero;
        out_full_r   <= cnt_full;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          front_r <= front_nxt;
          back_r  <= back_nxt;
          if (acc) begin
            res_status_r <= status_nxt;
            res_read_r   <= '0;
            if (mem_re) begin
              // The holding stage stays empty until the store answers.
              state_r     <= S_READ;
              res_valid_r <= 1'b0;
            end else begin
              res_valid_r <= 1'b1;
            end
          end else if (xfer) begin
            res_valid_r <= 1'b0;
          end
        end
        S_READ: begin
          unique case (dest_r)
            D_FRONT: front_r    <= mem_rdata_r;
            D_BACK:  back_r     <= mem_rdata_r;
            default: res_read_r <= mem_rdata_r;
          endcase
          res_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;
  assign out_read_value  = out_read_r;
  assign out_occupancy   = out_occ_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

  // The count never passes the capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("deque count exceeds capacity");

  // An empty queue has both pointers back at index zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_zero |-> (head_r == '0) && (tail_r == '0))
    else $error("empty deque with pointers away from zero");

  // A memory read always completes into the holding stage on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> res_valid_r && (state_r == S_IDLE))
    else $error("read cycle did not complete a result");

  // A result that cannot drain blocks any new request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && out_valid_r && !out_ready) |-> !acc)
    else $error("request accepted over an undrained result");

  // A full queue keeps one pointer step between tail and head.
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_full |-> (tail_inc == head_r))
    else $error("full deque with inconsistent pointers");

endmodule

`default_nettype wire
